### rtl/beat_clock_tempo_lock_macros.svh
// Assertion macros for the beat clock with tempo lock
`ifndef BEAT_CLOCK_TEMPO_LOCK_MACROS_SVH
`define BEAT_CLOCK_TEMPO_LOCK_MACROS_SVH

// Check a consequence in the same cycle as its condition
`define BCTL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its condition
`define BCTL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bctl_pkg.sv
// Constants and codes for the beat clock with tempo lock
package bctl_pkg;

	// Width of the shared divider datapath
	localparam int DIV_W = 64;
	localparam int PERIOD_W = 31;

	// Q8 period numerator: 60 s in Q8 microseconds times 100
	localparam logic [DIV_W-1:0] TEMPO_NUM = 64'd1536000000000;
	localparam logic [DIV_W-1:0] PERIOD_MAX = 64'h7FFF_FFFF;
	localparam logic [DIV_W-1:0] GAP_SAT = 64'h003F_FFFF_FFFF_FFFF;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 31'd128000000;

	// Event kinds
	localparam logic [1:0] FUNC_MARK = 2'd0;
	localparam logic [1:0] FUNC_TEMPO = 2'd1;
	localparam logic [1:0] FUNC_RESTART = 2'd2;
	localparam logic [1:0] FUNC_QUERY = 2'd3;

	// Beat sources
	localparam logic [1:0] SRC_INTERNAL = 2'd0;
	localparam logic [1:0] SRC_TAP = 2'd3;

	// Accept modes
	localparam logic [1:0] MODE_EXACT = 2'd0;
	localparam logic [1:0] MODE_GRID = 2'd1;
	localparam logic [1:0] MODE_FRESH = 2'd2;

	// Register indexes
	localparam logic [2:0] REG_MIN_BPM = 3'd0;
	localparam logic [2:0] REG_MAX_BPM = 3'd1;
	localparam logic [2:0] REG_SNAP_WINDOW = 3'd2;
	localparam logic [2:0] REG_SETTLE_BEATS = 3'd3;
	localparam logic [2:0] REG_RELOCK_BEATS = 3'd4;
	localparam logic [2:0] REG_TIMEOUT = 3'd5;
	localparam logic [2:0] REG_FREE_RUN = 3'd6;
	localparam logic [2:0] REG_BEATS_PER_BAR = 3'd7;

endpackage

### rtl/beat_clock_tempo_lock.sv
// Beat clock with tempo lock: sequencer around one shared iterative divider
//
// Usage: an event item (func, time_us, beat_source, bpm_x100) enters on the in_valid /
// in_ready channel; exactly one result item leaves on out_valid / out_ready. Registers
// are written on the cfg_valid / cfg_ready channel (always ready); the user must write
// them only while no item is in flight, which the block does not enforce. in_ready is
// high only while the sequencer is idle, one item at a time. Every division goes through
// one restoring divider that retires one quotient bit a cycle. An item needs two divisions
// for the tempo limits, up to seven more for tempo, grid position, snapping, learning and
// bar position, plus sequencing states between them. The divider loop sets the rate.
// The result waits in an output register; if the receiver stalls, the next item is still
// taken and processed, and its result is held back until the previous one is taken.
// Reset (arst_n low) restores the registers to their defaults and the grid to 120 bpm,
// with no anchor, no beat taken and no external link.
`include "beat_clock_tempo_lock_macros.svh"

module beat_clock_tempo_lock #(
	parameter int TIME_BITS = 48,
	parameter int COUNT_BITS = 48,
	parameter int PHASE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	// event items
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            func,
	input  logic [TIME_BITS-1:0]  time_us,
	input  logic [1:0]            beat_source,
	input  logic [16:0]           bpm_x100,
	// result items
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COUNT_BITS-1:0] beat_count,
	output logic [PHASE_BITS-1:0] beat_phase,
	output logic [3:0]            bar_beat,
	output logic [22:0]           period_us,
	output logic                  is_locked,
	output logic [1:0]            active_source,
	output logic                  grid_moved,
	output logic [31:0]           external_total
);

	localparam int DW = bctl_pkg::DIV_W;
	localparam int PW = bctl_pkg::PERIOD_W;

	// Sequencer states
	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_LO      = 5'd1;
	localparam logic [4:0] ST_LO_END  = 5'd2;
	localparam logic [4:0] ST_HI      = 5'd3;
	localparam logic [4:0] ST_HI_END  = 5'd4;
	localparam logic [4:0] ST_DISP    = 5'd5;
	localparam logic [4:0] ST_SNAP    = 5'd6;
	localparam logic [4:0] ST_IV      = 5'd7;
	localparam logic [4:0] ST_ACC     = 5'd8;
	localparam logic [4:0] ST_ACC_END = 5'd9;
	localparam logic [4:0] ST_SMOOTH  = 5'd10;
	localparam logic [4:0] ST_TS_NP   = 5'd11;
	localparam logic [4:0] ST_TS_MUL  = 5'd12;
	localparam logic [4:0] ST_TS_END  = 5'd13;
	localparam logic [4:0] ST_FINAL   = 5'd14;
	localparam logic [4:0] ST_BAR     = 5'd15;
	localparam logic [4:0] ST_BAR_END = 5'd16;
	localparam logic [4:0] ST_EMIT    = 5'd17;
	localparam logic [4:0] ST_GRID    = 5'd18;
	localparam logic [4:0] ST_GRID_W  = 5'd19;
	localparam logic [4:0] ST_GRID_F  = 5'd20;
	localparam logic [4:0] ST_DIV     = 5'd21;

	logic [4:0] state_q, dret_q, gret_q;

	// Configuration registers
	logic [16:0] min_bpm_q, max_bpm_q;
	logic [7:0]  snap_q, settle_beats_q, relock_q;
	logic [31:0] timeout_q;
	logic        free_run_q;
	logic [4:0]  bpb_q;

	// Latched event
	logic [1:0]           func_q, src_q;
	logic [TIME_BITS-1:0] now_q;
	logic [16:0]          bpm_q;

	// Grid state
	logic [PW-1:0]         period_q;
	logic [TIME_BITS-1:0]  anchor_time_q, taken_time_q, ext_time_q;
	logic                  anchor_valid_q, taken_valid_q, ext_valid_q;
	logic [COUNT_BITS-1:0] current_q, taken_beat_q, downbeat_q;
	logic [31:0]           ext_count_q;
	logic [7:0]            settle_q, stray_q;
	logic [1:0]            source_q;

	// Working registers
	logic [PW-1:0]           lo_q, hi_q, np_q;
	logic [DW-1:0]           gq8_q, iv_q, steps_q;
	logic                    iv_skip_q, moved_q, whole_nz_q, rel_neg_q;
	logic [1:0]              mode_q;
	logic [PHASE_BITS+PW-1:0] prod_q;
	logic [COUNT_BITS-1:0]   g_beat_q;
	logic [PHASE_BITS-1:0]   g_frac_q;
	logic [3:0]              bar_q;

	// Divider registers
	logic [DW-1:0] div_num_q, div_den_q, div_rem_q;
	logic [5:0]    div_cnt_q;

	// Output register
	logic                  out_valid_q;
	logic [COUNT_BITS-1:0] beat_count_q;
	logic [PHASE_BITS-1:0] beat_phase_q;
	logic [3:0]            bar_beat_q;
	logic [22:0]           period_us_q;
	logic                  is_locked_q, grid_moved_q;
	logic [1:0]            active_source_q;
	logic [31:0]           external_total_q;

	// Combinational helpers
	logic [DW:0]           rem_sh;
	logic                  div_ge;
	logic [DW:0]           rem_nx;
	logic [PW-1:0]         safe_p, quo_sat;
	logic [DW-1:0]         p_w;
	logic                  lock_now, neg;
	logic [DW-1:0]         gap, gap_sat, gap_q8, d_raw, d_sat, dq;
	logic                  round_up, agrees;
	logic [DW-1:0]         steps_c, diff_c;
	logic [PW+7:0]         lhs, rhs;
	logic [7:0]            stray_inc;
	logic [16:0]           v_lo, v_clamp;
	logic [COUNT_BITS-1:0] next_base, show, acc_next, rel, rel_mag;
	logic [4:0]            bpb_c, bar_r;
	logic                  sm_ok;
	logic [DW-1:0]         sm_sum, off_w;

	// One restoring divider step
	always_comb begin
		rem_sh = {div_rem_q, div_num_q[DW-1]};
		div_ge = rem_sh >= {1'b0, div_den_q};
		rem_nx = div_ge ? rem_sh - {1'b0, div_den_q} : rem_sh;
	end

	// Period and tempo helpers
	always_comb begin
		safe_p = (period_q == '0) ? PW'(1) : period_q;
		p_w = DW'(safe_p);
		quo_sat = (div_num_q > bctl_pkg::PERIOD_MAX) ? PW'(bctl_pkg::PERIOD_MAX) :
			div_num_q[PW-1:0];
		v_lo = (bpm_q < min_bpm_q) ? min_bpm_q : bpm_q;
		v_clamp = (v_lo > max_bpm_q) ? max_bpm_q : v_lo;
	end

	// Lock, gap and elapsed time
	always_comb begin
		lock_now = ext_valid_q && ((now_q < ext_time_q) ||
			(DW'(now_q - ext_time_q) < DW'(timeout_q)));
		neg = !taken_valid_q || (now_q < taken_time_q);
		gap = DW'(now_q - taken_time_q);
		gap_sat = (gap > bctl_pkg::GAP_SAT) ? bctl_pkg::GAP_SAT : gap;
		gap_q8 = gap_sat << 8;
		d_raw = (now_q > anchor_time_q) ? DW'(now_q - anchor_time_q) : '0;
		d_sat = (d_raw > bctl_pkg::GAP_SAT) ? bctl_pkg::GAP_SAT : d_raw;
		dq = d_sat << 8;
	end

	// Grid agreement from quotient and remainder of gap over period
	always_comb begin
		round_up = {div_rem_q, 1'b0} >= {1'b0, p_w};
		steps_c = round_up ? div_num_q + DW'(1) : div_num_q;
		diff_c = round_up ? p_w - div_rem_q : div_rem_q;
		lhs = {diff_c[PW-1:0], 8'd0};
		rhs = (PW+8)'(snap_q) * (PW+8)'(safe_p);
		agrees = lhs <= rhs;
		stray_inc = (stray_q == 8'hFF) ? stray_q : stray_q + 8'd1;
	end

	// Beat acceptance, smoothing, tempo offset and bar position
	always_comb begin
		next_base = taken_beat_q + COUNT_BITS'(steps_q);
		show = (mode_q == bctl_pkg::MODE_FRESH) ? g_beat_q + COUNT_BITS'(1) : g_beat_q;
		acc_next = ((mode_q != bctl_pkg::MODE_EXACT) && (show > next_base)) ?
			show : next_base;
		sm_ok = !iv_skip_q && (iv_q >= DW'(lo_q)) && (iv_q <= DW'(hi_q));
		sm_sum = (DW'(period_q) << 1) + DW'(period_q) + iv_q + DW'(2);
		off_w = (DW'(prod_q) + (DW'(1) << (PHASE_BITS + 7))) >> (PHASE_BITS + 8);
		rel = g_beat_q - downbeat_q;
		rel_mag = rel[COUNT_BITS-1] ? COUNT_BITS'(0) - rel : rel;
		bpb_c = (bpb_q == 5'd0) ? 5'd1 : ((bpb_q > 5'd16) ? 5'd16 : bpb_q);
		bar_r = div_rem_q[4:0];
	end

	// Sequencer, divider, state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dret_q <= ST_IDLE;
			gret_q <= ST_IDLE;
			min_bpm_q <= 17'd4000;
			max_bpm_q <= 17'd24000;
			snap_q <= 8'd64;
			settle_beats_q <= 8'd4;
			relock_q <= 8'd4;
			timeout_q <= 32'd2000000;
			free_run_q <= 1'b1;
			bpb_q <= 5'd4;
			func_q <= bctl_pkg::FUNC_QUERY;
			src_q <= bctl_pkg::SRC_INTERNAL;
			now_q <= '0;
			bpm_q <= '0;
			period_q <= bctl_pkg::PERIOD_RESET;
			anchor_time_q <= '0;
			anchor_valid_q <= 1'b0;
			current_q <= '0;
			taken_beat_q <= '0;
			taken_time_q <= '0;
			taken_valid_q <= 1'b0;
			ext_time_q <= '0;
			ext_valid_q <= 1'b0;
			ext_count_q <= '0;
			settle_q <= '0;
			stray_q <= '0;
			downbeat_q <= '0;
			source_q <= bctl_pkg::SRC_INTERNAL;
			lo_q <= '0;
			hi_q <= '0;
			np_q <= '0;
			gq8_q <= '0;
			iv_q <= '0;
			steps_q <= '0;
			iv_skip_q <= 1'b1;
			moved_q <= 1'b0;
			whole_nz_q <= 1'b0;
			rel_neg_q <= 1'b0;
			mode_q <= bctl_pkg::MODE_EXACT;
			prod_q <= '0;
			g_beat_q <= '0;
			g_frac_q <= '0;
			bar_q <= '0;
			div_num_q <= '0;
			div_den_q <= '0;
			div_rem_q <= '0;
			div_cnt_q <= '0;
			out_valid_q <= 1'b0;
			beat_count_q <= '0;
			beat_phase_q <= '0;
			bar_beat_q <= '0;
			period_us_q <= '0;
			is_locked_q <= 1'b0;
			grid_moved_q <= 1'b0;
			active_source_q <= '0;
			external_total_q <= '0;
		end else begin
			// Write configuration registers
			if (cfg_valid) begin
				unique case (cfg_index)
					bctl_pkg::REG_MIN_BPM:       min_bpm_q <= cfg_data[16:0];
					bctl_pkg::REG_MAX_BPM:       max_bpm_q <= cfg_data[16:0];
					bctl_pkg::REG_SNAP_WINDOW:   snap_q <= cfg_data[7:0];
					bctl_pkg::REG_SETTLE_BEATS:  settle_beats_q <= cfg_data[7:0];
					bctl_pkg::REG_RELOCK_BEATS:  relock_q <= cfg_data[7:0];
					bctl_pkg::REG_TIMEOUT:       timeout_q <= cfg_data;
					bctl_pkg::REG_FREE_RUN:      free_run_q <= cfg_data[0];
					bctl_pkg::REG_BEATS_PER_BAR: bpb_q <= cfg_data[4:0];
				endcase
			end

			// Drop the result once taken
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						func_q <= func;
						now_q <= time_us;
						src_q <= beat_source;
						bpm_q <= bpm_x100;
						moved_q <= 1'b0;
						state_q <= ST_LO;
					end
				end
				// Q8 period of the fastest tempo
				ST_LO: begin
					div_num_q <= bctl_pkg::TEMPO_NUM + DW'(max_bpm_q >> 1);
					div_den_q <= (max_bpm_q == '0) ? DW'(1) : DW'(max_bpm_q);
					div_rem_q <= '0;
					div_cnt_q <= '1;
					dret_q <= ST_LO_END;
					state_q <= ST_DIV;
				end
				ST_LO_END: begin
					lo_q <= quo_sat;
					state_q <= ST_HI;
				end
				// Q8 period of the slowest tempo
				ST_HI: begin
					div_num_q <= bctl_pkg::TEMPO_NUM + DW'(min_bpm_q >> 1);
					div_den_q <= (min_bpm_q == '0) ? DW'(1) : DW'(min_bpm_q);
					div_rem_q <= '0;
					div_cnt_q <= '1;
					dret_q <= ST_HI_END;
					state_q <= ST_DIV;
				end
				ST_HI_END: begin
					hi_q <= quo_sat;
					state_q <= ST_DISP;
				end
				ST_DISP: begin
					unique case (func_q)
						bctl_pkg::FUNC_MARK: begin
							source_q <= src_q;
							if (src_q != bctl_pkg::SRC_INTERNAL) begin
								ext_time_q <= now_q;
								ext_valid_q <= 1'b1;
								ext_count_q <= ext_count_q + 32'd1;
							end
							iv_q <= gap_q8;
							iv_skip_q <= neg;
							steps_q <= DW'(1);
							if (src_q == bctl_pkg::SRC_INTERNAL || src_q == bctl_pkg::SRC_TAP) begin
								settle_q <= '0;
								mode_q <= bctl_pkg::MODE_EXACT;
								state_q <= ST_ACC;
							end else if (!lock_now || !taken_valid_q) begin
								settle_q <= '0;
								mode_q <= bctl_pkg::MODE_GRID;
								state_q <= ST_ACC;
							end else if (neg || gap_q8 < DW'(lo_q)) begin
								state_q <= ST_FINAL;
							end else begin
								gq8_q <= gap_q8;
								div_num_q <= gap_q8;
								div_den_q <= p_w;
								div_rem_q <= '0;
								div_cnt_q <= '1;
								dret_q <= ST_SNAP;
								state_q <= ST_DIV;
							end
						end
						bctl_pkg::FUNC_TEMPO: begin
							div_num_q <= bctl_pkg::TEMPO_NUM + DW'(v_clamp >> 1);
							div_den_q <= (v_clamp == '0) ? DW'(1) : DW'(v_clamp);
							div_rem_q <= '0;
							div_cnt_q <= '1;
							dret_q <= ST_TS_NP;
							state_q <= ST_DIV;
						end
						bctl_pkg::FUNC_RESTART: begin
							steps_q <= DW'(1);
							mode_q <= bctl_pkg::MODE_FRESH;
							state_q <= ST_ACC;
						end
						bctl_pkg::FUNC_QUERY: begin
							state_q <= ST_FINAL;
						end
					endcase
				end
				// Settled link: snap, count strays or acquire
				ST_SNAP: begin
					iv_q <= gq8_q;
					iv_skip_q <= 1'b0;
					mode_q <= bctl_pkg::MODE_GRID;
					steps_q <= DW'(1);
					if (settle_q < settle_beats_q) begin
						settle_q <= (agrees && steps_c == DW'(1)) ? settle_q + 8'd1 : 8'd0;
						state_q <= ST_ACC;
					end else if (!agrees) begin
						stray_q <= stray_inc;
						if (stray_inc < relock_q) begin
							state_q <= ST_FINAL;
						end else begin
							settle_q <= '0;
							state_q <= ST_ACC;
						end
					end else if (steps_c == '0) begin
						state_q <= ST_FINAL;
					end else begin
						steps_q <= steps_c;
						div_num_q <= gq8_q + (steps_c >> 1);
						div_den_q <= steps_c;
						div_rem_q <= '0;
						div_cnt_q <= '1;
						dret_q <= ST_IV;
						state_q <= ST_DIV;
					end
				end
				ST_IV: begin
					iv_q <= div_num_q;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (mode_q == bctl_pkg::MODE_EXACT) begin
						state_q <= ST_ACC_END;
					end else begin
						gret_q <= ST_ACC_END;
						state_q <= ST_GRID;
					end
				end
				// Move the grid to the taken beat
				ST_ACC_END: begin
					current_q <= acc_next;
					taken_beat_q <= acc_next;
					taken_time_q <= now_q;
					taken_valid_q <= 1'b1;
					anchor_time_q <= now_q;
					anchor_valid_q <= 1'b1;
					stray_q <= '0;
					moved_q <= 1'b1;
					if (func_q == bctl_pkg::FUNC_RESTART) begin
						downbeat_q <= acc_next;
						settle_q <= '0;
						source_q <= src_q;
						if (src_q != bctl_pkg::SRC_INTERNAL) begin
							ext_time_q <= now_q;
							ext_valid_q <= 1'b1;
						end
						state_q <= ST_FINAL;
					end else begin
						state_q <= ST_SMOOTH;
					end
				end
				// Blend a learned interval into the period
				ST_SMOOTH: begin
					if (sm_ok) begin
						period_q <= sm_sum[PW+1:2];
					end
					state_q <= ST_FINAL;
				end
				ST_TS_NP: begin
					np_q <= quo_sat;
					gret_q <= ST_TS_MUL;
					state_q <= ST_GRID;
				end
				ST_TS_MUL: begin
					prod_q <= (PHASE_BITS+PW)'(g_frac_q) * (PHASE_BITS+PW)'(np_q);
					state_q <= ST_TS_END;
				end
				// Keep the phase across the tempo change
				ST_TS_END: begin
					period_q <= np_q;
					current_q <= g_beat_q;
					anchor_time_q <= (DW'(now_q) > off_w) ? now_q - TIME_BITS'(off_w) : '0;
					anchor_valid_q <= 1'b1;
					source_q <= src_q;
					state_q <= ST_FINAL;
				end
				ST_FINAL: begin
					gret_q <= ST_BAR;
					state_q <= ST_GRID;
				end
				ST_BAR: begin
					rel_neg_q <= rel[COUNT_BITS-1];
					div_num_q <= DW'(rel_mag);
					div_den_q <= DW'(bpb_c);
					div_rem_q <= '0;
					div_cnt_q <= '1;
					dret_q <= ST_BAR_END;
					state_q <= ST_DIV;
				end
				ST_BAR_END: begin
					if (rel_neg_q) begin
						bar_q <= (bar_r != '0) ? 4'(bpb_c - bar_r) : 4'd0;
					end else begin
						bar_q <= bar_r[3:0];
					end
					state_q <= ST_EMIT;
				end
				// Hold the result until the output register is free
				ST_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						beat_count_q <= g_beat_q;
						beat_phase_q <= g_frac_q;
						bar_beat_q <= bar_q;
						period_us_q <= period_q[PW-1:8];
						is_locked_q <= lock_now;
						active_source_q <= source_q;
						grid_moved_q <= moved_q;
						external_total_q <= ext_count_q;
						state_q <= ST_IDLE;
					end
				end
				// Grid position at the event time
				ST_GRID: begin
					if (!anchor_valid_q) begin
						g_beat_q <= current_q;
						g_frac_q <= '0;
						state_q <= gret_q;
					end else begin
						div_num_q <= dq;
						div_den_q <= p_w;
						div_rem_q <= '0;
						div_cnt_q <= '1;
						dret_q <= ST_GRID_W;
						state_q <= ST_DIV;
					end
				end
				ST_GRID_W: begin
					g_beat_q <= current_q + COUNT_BITS'(div_num_q);
					whole_nz_q <= div_num_q != '0;
					div_num_q <= div_rem_q << PHASE_BITS;
					div_den_q <= p_w;
					div_rem_q <= '0;
					div_cnt_q <= '1;
					dret_q <= ST_GRID_F;
					state_q <= ST_DIV;
				end
				ST_GRID_F: begin
					if (!free_run_q && whole_nz_q) begin
						g_beat_q <= current_q;
						g_frac_q <= '1;
					end else begin
						g_frac_q <= div_num_q[PHASE_BITS-1:0];
					end
					state_q <= gret_q;
				end
				// Retire one quotient bit a cycle
				ST_DIV: begin
					div_num_q <= {div_num_q[DW-2:0], div_ge};
					div_rem_q <= rem_nx[DW-1:0];
					div_cnt_q <= div_cnt_q - 6'd1;
					if (div_cnt_q == '0) begin
						state_q <= dret_q;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign beat_count = beat_count_q;
	assign beat_phase = beat_phase_q;
	assign bar_beat = bar_beat_q;
	assign period_us = period_us_q;
	assign is_locked = is_locked_q;
	assign active_source = active_source_q;
	assign grid_moved = grid_moved_q;
	assign external_total = external_total_q;

	`BCTL_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "sequencer still idle after taking an item")
	`BCTL_ASSERT_NOW(a_period_nonzero, 1'b1, period_q != '0, "beat period reached zero")
	`BCTL_ASSERT_NOW(a_emit_source, $rose(out_valid_q), $past(state_q == ST_EMIT), "result raised outside emit")
	`BCTL_ASSERT_NOW(a_taken_anchored, taken_valid_q, anchor_valid_q, "beat taken without an anchor")

endmodule
